/* sv/mrfc_pkg.sv */
package mrfc_pkg;

    localparam logic [2:0] FRAME_LEN    = 3'd7;
    localparam logic [2:0] CRC_SPAN     = 3'd5;
    localparam logic [2:0] VALUE_HI_IDX = 3'd3;
    localparam logic [2:0] VALUE_LO_IDX = 3'd4;
    localparam logic [2:0] CRC_LO_IDX   = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_CRC   = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* sv/modbus_reply_frame_checker.sv */
// Checks seven-byte Modbus RTU register-read replies. Each input beat is a received byte, a
// start mark that clears the frame, or a receive timeout. The closing byte, or a timeout on an
// open frame, gives one output beat: the big-endian register value from bytes 3 and 4 with
// status ok, or zero with status crc mismatch or short frame. A beat is taken every cycle while
// the output register is free or being read; a result passes through the input register, then the
// combinational unrolled crc byte update, into the output register. Bytes after a closed
// frame and timeouts on a closed frame give nothing until the next start.
module modbus_reply_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // reg_value
    output logic [1:0]  m_axis_tuser    // status
);

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_byte_reg;

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic [1:0]  out_status_reg;

    logic        adv;
    logic        proc;
    logic        res_valid;
    logic [15:0] res_value;
    logic [1:0]  res_status;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;
    assign proc          = in_valid_reg && adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // frame state and result
    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        value_next      = value_reg;
        crc_low_next    = crc_low_reg;
        res_valid       = 1'b0;
        res_value       = 16'h0000;
        res_status      = mrfc_pkg::STATUS_OK;
        if (proc)
        begin
            case (in_kind_reg)
                mrfc_pkg::KIND_START:
                begin
                    byte_count_next = 3'd0;
                    crc_next        = mrfc_pkg::CRC_INIT;
                    value_next      = 16'h0000;
                    crc_low_next    = 8'h00;
                end
                mrfc_pkg::KIND_TIMEOUT:
                begin
                    if (byte_count_reg < mrfc_pkg::FRAME_LEN)
                    begin
                        byte_count_next = mrfc_pkg::FRAME_LEN;
                        res_valid       = 1'b1;
                        res_status      = mrfc_pkg::STATUS_SHORT;
                    end
                end
                mrfc_pkg::KIND_BYTE:
                begin
                    if (byte_count_reg < mrfc_pkg::FRAME_LEN)
                    begin
                        if (byte_count_reg < mrfc_pkg::CRC_SPAN)
                            crc_next = mrfc_pkg::crc_update(crc_reg, in_byte_reg);
                        if (byte_count_reg == mrfc_pkg::VALUE_HI_IDX)
                            value_next = {in_byte_reg, value_reg[7:0]};
                        else if (byte_count_reg == mrfc_pkg::VALUE_LO_IDX)
                            value_next = {value_reg[15:8], in_byte_reg};
                        else if (byte_count_reg == mrfc_pkg::CRC_LO_IDX)
                            crc_low_next = in_byte_reg;
                        if (byte_count_reg == mrfc_pkg::FRAME_LEN - 3'd1)
                        begin
                            byte_count_next = mrfc_pkg::FRAME_LEN;
                            res_valid       = 1'b1;
                            if ({in_byte_reg, crc_low_reg} == crc_reg)
                            begin
                                res_value  = value_reg;
                                res_status = mrfc_pkg::STATUS_OK;
                            end
                            else
                            begin
                                res_status = mrfc_pkg::STATUS_CRC;
                            end
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 3'd0;
            crc_reg        <= mrfc_pkg::CRC_INIT;
            value_reg      <= 16'h0000;
            crc_low_reg    <= 8'h00;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            value_reg      <= value_next;
            crc_low_reg    <= crc_low_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != mrfc_pkg::STATUS_OK) |-> m_axis_tdata == 16'h0000)
        else $error("nonzero value on failed frame");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= mrfc_pkg::FRAME_LEN)
        else $error("byte count beyond frame length");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_kind_reg == mrfc_pkg::KIND_START)
        |=> (byte_count_reg == 3'd0 && crc_reg == mrfc_pkg::CRC_INIT))
        else $error("start beat did not clear frame");

    a_result_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid) |=> (byte_count_reg == mrfc_pkg::FRAME_LEN && m_axis_tvalid))
        else $error("result without closing frame");

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  status;
    } reply_t;

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ mrfc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    class reply_scoreboard;
        logic [2:0]  bytes_taken;
        logic [15:0] crc_acc;
        logic [15:0] value_hold;
        logic [7:0]  crc_lo;
        reply_t      pending[$];
        int          errors;

        function new();
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            bytes_taken = '0;
            crc_acc     = mrfc_pkg::CRC_INIT;
            value_hold  = '0;
            crc_lo      = '0;
        endfunction

        // returns 1 unless the beat is ignored
        function bit note_beat(input logic [1:0] kind, input logic [7:0] data);
            reply_t r;
            if (kind == mrfc_pkg::KIND_START)
            begin
                clear_frame();
                return 1'b1;
            end
            if (bytes_taken >= mrfc_pkg::FRAME_LEN ||
                (kind != mrfc_pkg::KIND_BYTE && kind != mrfc_pkg::KIND_TIMEOUT))
                return 1'b0;
            if (kind == mrfc_pkg::KIND_TIMEOUT)
            begin
                bytes_taken = mrfc_pkg::FRAME_LEN;
                r.value     = '0;
                r.status    = mrfc_pkg::STATUS_SHORT;
                pending.push_back(r);
                return 1'b1;
            end
            if (bytes_taken < mrfc_pkg::CRC_SPAN)
                crc_acc = crc16_modbus_byte(crc_acc, data);
            case (bytes_taken)
                mrfc_pkg::VALUE_HI_IDX: value_hold[15:8] = data;
                mrfc_pkg::VALUE_LO_IDX: value_hold[7:0]  = data;
                mrfc_pkg::CRC_LO_IDX:   crc_lo           = data;
                default: ;
            endcase
            if (bytes_taken == mrfc_pkg::FRAME_LEN - 3'd1)
            begin
                bytes_taken = mrfc_pkg::FRAME_LEN;
                if ({data, crc_lo} == crc_acc)
                begin
                    r.value  = value_hold;
                    r.status = mrfc_pkg::STATUS_OK;
                end
                else
                begin
                    r.value  = '0;
                    r.status = mrfc_pkg::STATUS_CRC;
                end
                pending.push_back(r);
            end
            else
                bytes_taken = bytes_taken + 3'd1;
            return 1'b1;
        endfunction

        function void check_reply(input logic [15:0] value, input logic [1:0] status);
            reply_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, got value %h status %0d",
                         $time, value, status);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
            begin
                errors++;
                $display("%0t: reg_value expected %h got %h", $time, want.value, value);
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, status);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 300000;
    localparam int BEAT_TARGET = 1050;
    localparam int HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // rx_byte
    logic [1:0]  s_axis_tuser  = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // reg_value
    logic [1:0]  m_axis_tuser;          // status

    reply_scoreboard sb;
    int          used_beats = 0;
    int          cycle_count = 0;
    bit          idle_on    = 1'b1;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    modbus_reply_frame_checker DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
        while (idle_on && $urandom_range(99, 0) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        void'(sb.note_beat(kind, data));
        used_beats++;
        @(negedge clk);
    endtask

    // body holds bytes 0..4, byte 0 lowest; the crc is appended low byte first
    task automatic send_frame(input logic [39:0] body, input bit corrupt);
        logic [15:0] crc;
        logic [55:0] frame;
        crc = mrfc_pkg::CRC_INIT;
        for (int i = 0; i < 5; i++)
            crc = crc16_modbus_byte(crc, body[8*i +: 8]);
        frame = {crc[15:8], crc[7:0], body};
        if (corrupt)
            frame[$urandom_range(55, 0)] ^= 1'b1;
        for (int i = 0; i < 7; i++)
            send_beat(mrfc_pkg::KIND_BYTE, frame[8*i +: 8]);
    endtask

    function automatic logic [39:0] random_body();
        logic [39:0] body;
        body[31:0]  = $urandom();
        body[39:32] = 8'($urandom_range(255, 0));
        return body;
    endfunction

    // receiver: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99, 0) < 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int pick;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme value with good crc, corrupted frame, short frame, ignored beats
        send_beat(mrfc_pkg::KIND_START, 8'h00);
        send_frame(40'hFF_FF_02_03_01, 1'b0);
        send_beat(mrfc_pkg::KIND_START, 8'hFF);
        send_frame(40'h00_00_00_00_00, 1'b1);
        send_beat(mrfc_pkg::KIND_START, 8'h00);
        send_beat(mrfc_pkg::KIND_BYTE, 8'h00);
        send_beat(mrfc_pkg::KIND_BYTE, 8'hFF);
        send_beat(mrfc_pkg::KIND_TIMEOUT, 8'hFF);
        send_beat(mrfc_pkg::KIND_TIMEOUT, 8'h00);
        send_beat(mrfc_pkg::KIND_BYTE, 8'h5A);
        send_beat(2'd3, 8'hA5);
        send_beat(mrfc_pkg::KIND_START, 8'h00);
        send_beat(mrfc_pkg::KIND_TIMEOUT, 8'h00);

        // back-pressure: receiver holds off while frames keep coming
        hold_req = 1'b1;
        repeat (12)
        begin
            send_beat(mrfc_pkg::KIND_START, 8'($urandom_range(255, 0)));
            send_frame(random_body(), $urandom_range(99, 0) < 20);
        end

        while (used_beats < BEAT_TARGET)
        begin
            idle_on = !(used_beats >= 400 && used_beats < 650);
            pick = $urandom_range(99, 0);
            send_beat(mrfc_pkg::KIND_START, 8'($urandom_range(255, 0)));
            if (pick < 65)
                send_frame(random_body(), $urandom_range(99, 0) < 20);
            else if (pick < 78)
            begin
                repeat ($urandom_range(6, 0))
                    send_beat(mrfc_pkg::KIND_BYTE, 8'($urandom_range(255, 0)));
                send_beat(mrfc_pkg::KIND_TIMEOUT, 8'($urandom_range(255, 0)));
            end
            else if (pick < 88)
            begin
                send_frame(random_body(), $urandom_range(99, 0) < 20);
                repeat ($urandom_range(3, 1))
                    send_beat(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
            end
            else
            begin
                repeat ($urandom_range(5, 1))
                    send_beat(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
            end
        end
        idle_on = 1'b1;
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* filelist.f */
sv/mrfc_pkg.sv
sv/modbus_reply_frame_checker.sv
bench/testbench.sv
